/* src/sbpm_pkg.sv */
package sbpm_pkg;

    localparam int BANDS = 64;
    localparam int IDX_W = $clog2(BANDS);

    localparam int Q_W   = 20;
    localparam int LC_W  = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [14:0] LOG10_2_Q16 = 15'd19728;

    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LIMIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_SCALE        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAR_FALL_STEP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FALL_GROWTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FALL_START  = 3'd4;

    localparam logic [7:0] LOG2_FRAC [32] = '{
        8'd0,   8'd11,  8'd22,  8'd33,  8'd44,  8'd54,  8'd63,  8'd73,
        8'd82,  8'd92,  8'd100, 8'd109, 8'd118, 8'd126, 8'd134, 8'd142,
        8'd150, 8'd157, 8'd165, 8'd172, 8'd179, 8'd186, 8'd193, 8'd200,
        8'd207, 8'd213, 8'd220, 8'd226, 8'd232, 8'd238, 8'd244, 8'd250
    };

    typedef struct packed {
        logic [5:0]  band;
        logic [15:0] magnitude;
    } t_in;

    typedef struct packed {
        logic [5:0] band_out;
        logic [9:0] bar_level;
        logic [9:0] peak_level;
    } t_out;

    typedef struct packed {
        logic [9:0]  height_limit;
        logic [15:0] log_scale;
        logic [15:0] bar_fall_step;
        logic [11:0] peak_fall_growth;
        logic [15:0] peak_fall_start;
    } t_cfg;

    typedef struct packed {
        logic [Q_W-1:0] bar;
        logic [Q_W-1:0] peak;
        logic [Q_W-1:0] speed;
    } t_band_state;

    // position of the leading one; zero input gives zero
    function automatic logic [3:0] lead_one(input logic [15:0] v);
        logic [3:0] p;
        p = 4'd0;
        for (int k = 1; k < 16; k++) begin
            if (v[k]) begin
                p = 4'(k);
            end
        end
        return p;
    endfunction

endpackage

/* src/sbpm_band_update.sv */
module sbpm_band_update (
    input  sbpm_pkg::t_band_state   i_state,
    input  logic [sbpm_pkg::Q_W-1:0] i_height,
    input  sbpm_pkg::t_cfg          i_cfg,
    output sbpm_pkg::t_band_state   o_state
);

    logic [sbpm_pkg::Q_W-1:0] step;
    logic [sbpm_pkg::Q_W-1:0] bar_n;
    logic [sbpm_pkg::Q_W-1:0] peak_dec;
    logic [31:0]              grown;
    logic [21:0]              grown_sh;
    logic [sbpm_pkg::Q_W-1:0] speed_grown;
    logic                     lift;
    logic                     new_peak;
    logic                     fall;

    assign step     = sbpm_pkg::Q_W'(i_cfg.bar_fall_step);
    assign lift     = i_height > i_state.bar;
    assign new_peak = lift && (i_height > i_state.peak);
    assign fall     = !new_peak && (i_state.peak != '0);

    assign bar_n = lift ? i_height :
                   (i_state.bar > step) ? i_state.bar - step : '0;

    assign peak_dec = (i_state.peak > i_state.speed) ? i_state.peak - i_state.speed : '0;

    assign grown       = 32'(i_state.speed) * 32'(i_cfg.peak_fall_growth);
    assign grown_sh    = grown[31:10];
    // saturate the grown speed at full scale
    assign speed_grown = (grown_sh[21:20] != 2'b00) ? '1 : grown_sh[19:0];

    always_comb begin
        o_state.bar   = bar_n;
        o_state.peak  = i_state.peak;
        o_state.speed = i_state.speed;
        if (new_peak) begin
            o_state.peak  = i_height;
            o_state.speed = sbpm_pkg::Q_W'(i_cfg.peak_fall_start);
        end else if (fall) begin
            o_state.peak  = (peak_dec < bar_n) ? bar_n : peak_dec;
            o_state.speed = speed_grown;
        end
    end

endmodule

/* src/spectrum_bar_peak_meter_top.sv */
// Spectrum bar and peak-hold meter.
// Input channel (i_in_valid / o_in_ready, payload i_in) takes one band number and
// linear magnitude per transaction; output channel (o_out_valid / i_out_ready,
// payload o_out) returns the band with its updated bar and peak heights in pixels.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes one register
// per transaction at i_cfg_index; the user must use it only while idle (the block does not enforce it).
// Pipeline: input register, log stage (leading one, fraction table, constant
// multiply), scale stage (gain multiply, clamp, band store read), update stage
// (compare, decay, speed multiply, store write), output register.
// Each result is presented from the output register after the update stage.
// Throughput: one transaction per cycle unless the output stalls; a result for the same band
// as the one just before it takes the updated state forwarded from the update stage.
// Each stage advances when the stage after it is empty or moving on, so bubbles
// are filled while the receiver stalls; the input stalls only once every stage
// holds an item.
// Reset clears the pipeline, loads register defaults and clears the per-band
// valid flags, so every band reads as zero at once with no clearing pass.
module spectrum_bar_peak_meter_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  sbpm_pkg::t_in                      i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output sbpm_pkg::t_out                     o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sbpm_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [sbpm_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    sbpm_pkg::t_cfg r_cfg;

    logic                        r_s1_vld;
    sbpm_pkg::t_in               r_s1;
    logic                        r_s2_vld;
    logic [5:0]                  r_s2_band;
    logic [sbpm_pkg::LC_W-1:0]   r_s2_lc;
    logic                        r_s3_vld;
    logic [5:0]                  r_s3_band;
    logic [sbpm_pkg::Q_W-1:0]    r_s3_h;
    sbpm_pkg::t_band_state       r_rd;
    logic                        r_rd_vld;
    logic                        r_out_vld;
    sbpm_pkg::t_out              r_out;

    sbpm_pkg::t_band_state       r_mem [sbpm_pkg::BANDS];
    logic [sbpm_pkg::BANDS-1:0]  r_vld;

    logic out_ld, s3_ld, s2_ld, s1_ld, s3_mv, in_fire;
    logic s3_in_range, s2_in_range, s3_wr, fwd;

    logic [3:0]                  s1_p;
    logic [15:0]                 s1_norm;
    logic [4:0]                  s1_idx;
    logic [10:0]                 s1_l;
    logic [sbpm_pkg::LC_W-1:0]   s1_lc;

    logic [41:0]                 s2_prod;
    logic [sbpm_pkg::Q_W-1:0]    s2_hraw;
    logic [sbpm_pkg::Q_W-1:0]    s2_lim;
    logic [sbpm_pkg::Q_W-1:0]    s2_h;

    sbpm_pkg::t_band_state       s3_state;
    sbpm_pkg::t_band_state       s3_next;
    sbpm_pkg::t_out              s3_res;

    logic [sbpm_pkg::IDX_W-1:0]  s2_addr;
    logic [sbpm_pkg::IDX_W-1:0]  s3_addr;

    // handshake chain
    assign out_ld  = !r_out_vld || i_out_ready;
    assign s3_ld   = !r_s3_vld || out_ld;
    assign s3_mv   = r_s3_vld && out_ld;
    assign s2_ld   = !r_s2_vld || s3_ld;
    assign s1_ld   = !r_s1_vld || s2_ld;
    assign in_fire = i_in_valid && s1_ld;

    assign o_in_ready  = s1_ld;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.height_limit     <= 10'd63;
            r_cfg.log_scale        <= 16'd2560;
            r_cfg.bar_fall_step    <= 16'd1434;
            r_cfg.peak_fall_growth <= 12'd1147;
            r_cfg.peak_fall_start  <= 16'd10;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sbpm_pkg::CFG_HEIGHT_LIMIT:     r_cfg.height_limit     <= i_cfg_data[9:0];
                sbpm_pkg::CFG_LOG_SCALE:        r_cfg.log_scale        <= i_cfg_data;
                sbpm_pkg::CFG_BAR_FALL_STEP:    r_cfg.bar_fall_step    <= i_cfg_data;
                sbpm_pkg::CFG_PEAK_FALL_GROWTH: r_cfg.peak_fall_growth <= i_cfg_data[11:0];
                sbpm_pkg::CFG_PEAK_FALL_START:  r_cfg.peak_fall_start  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // log2 above 256 in Q3.8: only leading-one positions 8..15 give a positive value
    assign s1_p    = sbpm_pkg::lead_one(r_s1.magnitude);
    assign s1_norm = r_s1.magnitude << (4'd15 - s1_p);
    assign s1_idx  = s1_norm[14:10];
    assign s1_l    = (r_s1.magnitude[15:8] != 8'd0) ?
                     {s1_p[2:0], sbpm_pkg::LOG2_FRAC[s1_idx]} : 11'd0;
    assign s1_lc   = sbpm_pkg::LC_W'(s1_l) * sbpm_pkg::LC_W'(sbpm_pkg::LOG10_2_Q16);

    assign s2_prod = 42'(r_s2_lc) * 42'(r_cfg.log_scale);
    assign s2_hraw = s2_prod[41:22];
    assign s2_lim  = {r_cfg.height_limit, 10'd0};
    assign s2_h    = (s2_hraw > s2_lim) ? s2_lim : s2_hraw;

    assign s2_in_range = 9'(r_s2_band) < 9'(sbpm_pkg::BANDS);
    assign s3_in_range = 9'(r_s3_band) < 9'(sbpm_pkg::BANDS);
    assign s2_addr     = r_s2_band[sbpm_pkg::IDX_W-1:0];
    assign s3_addr     = r_s3_band[sbpm_pkg::IDX_W-1:0];
    assign s3_wr       = s3_mv && s3_in_range;
    // forward the state being written to a follower on the same band
    assign fwd         = s3_wr && s2_in_range && (s2_addr == s3_addr);

    assign s3_state = r_rd_vld ? r_rd : '0;

    sbpm_band_update u_update (
        .i_state  (s3_state),
        .i_height (r_s3_h),
        .i_cfg    (r_cfg),
        .o_state  (s3_next)
    );

    always_comb begin
        s3_res.band_out   = r_s3_band;
        s3_res.bar_level  = '0;
        s3_res.peak_level = '0;
        if (s3_in_range) begin
            s3_res.bar_level  = s3_next.bar[19:10];
            s3_res.peak_level = s3_next.peak[19:10];
        end
    end

    // pipeline valids and per-band valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_vld     <= '0;
        end else begin
            if (s1_ld) begin
                r_s1_vld <= in_fire;
            end
            if (s2_ld) begin
                r_s2_vld <= r_s1_vld;
            end
            if (s3_ld) begin
                r_s3_vld <= r_s2_vld;
                r_rd_vld <= fwd || r_vld[s2_addr];
            end
            if (out_ld) begin
                r_out_vld <= r_s3_vld;
            end
            if (s3_wr) begin
                r_vld[s3_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= i_in;
        end
        if (s2_ld) begin
            r_s2_band <= r_s1.band;
            r_s2_lc   <= s1_lc;
        end
        if (s3_ld) begin
            r_s3_band <= r_s2_band;
            r_s3_h    <= s2_h;
        end
        if (out_ld) begin
            r_out <= s3_res;
        end
    end

    // band store: registered read, bypassed by a same-cycle write
    always_ff @(posedge i_clk) begin
        if (s3_ld) begin
            if (fwd) begin
                r_rd <= s3_next;
            end else begin
                r_rd <= r_mem[s2_addr];
            end
        end
        if (s3_wr) begin
            r_mem[s3_addr] <= s3_next;
        end
    end

endmodule

/* dv/meter_checker.sv */
module meter_checker
    import sbpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in                   i_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out                  i_out,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [Q_W-1:0] Q_FULL       = '1;
    localparam int             REPORT_LIMIT = 10;
    localparam longint unsigned LOG10_OF_2  = 19728;

    localparam t_cfg CFG_DEFAULT = '{
        height_limit:     10'd63,
        log_scale:        16'd2560,
        bar_fall_step:    16'd1434,
        peak_fall_growth: 12'd1147,
        peak_fall_start:  16'd10
    };

    // log2 of 1 + i/32 in Q0.8
    localparam logic [7:0] FRAC_LOG2 [32] = '{
        8'd0,   8'd11,  8'd22,  8'd33,  8'd44,  8'd54,  8'd63,  8'd73,
        8'd82,  8'd92,  8'd100, 8'd109, 8'd118, 8'd126, 8'd134, 8'd142,
        8'd150, 8'd157, 8'd165, 8'd172, 8'd179, 8'd186, 8'd193, 8'd200,
        8'd207, 8'd213, 8'd220, 8'd226, 8'd232, 8'd238, 8'd244, 8'd250
    };

    t_cfg           meter_cfg;
    logic [Q_W-1:0] bar_q   [BANDS];
    logic [Q_W-1:0] peak_q  [BANDS];
    logic [Q_W-1:0] speed_q [BANDS];
    t_out           expected_levels [$];

    // log10(mag / 256) * gain in Q10.10, clamped to the display height
    function automatic logic [Q_W-1:0] log_height(input logic [15:0] mag);
        int              msb;
        logic [15:0]     norm;
        int              lg;
        longint unsigned h;
        longint unsigned lim;
        if (mag == 16'd0) begin
            return '0;
        end
        msb = 0;
        for (int k = 0; k < 16; k++) begin
            if (mag[k]) begin
                msb = k;
            end
        end
        norm = mag << (15 - msb);
        lg = msb * 256 + int'(FRAC_LOG2[norm[14:10]]) - 2048;
        if (lg <= 0) begin
            return '0;
        end
        h = (64'(lg) * LOG10_OF_2 * 64'(meter_cfg.log_scale)) >> 22;
        lim = 64'(meter_cfg.height_limit) << 10;
        if (h > lim) begin
            h = lim;
        end
        return h[Q_W-1:0];
    endfunction

    function automatic t_out meter_step(input t_in item);
        t_out            res;
        logic [Q_W-1:0]  h;
        logic [Q_W-1:0]  bar;
        logic [Q_W-1:0]  peak;
        logic [Q_W-1:0]  speed;
        bit              drop_peak;
        longint unsigned grown;
        res.band_out = item.band;
        h = log_height(item.magnitude);
        if (int'(item.band) >= BANDS) begin
            res.bar_level  = '0;
            res.peak_level = '0;
            return res;
        end
        bar       = bar_q[item.band];
        peak      = peak_q[item.band];
        speed     = speed_q[item.band];
        drop_peak = 1'b0;
        if (h > bar) begin
            bar = h;
            if (h > peak) begin
                peak  = h;
                speed = Q_W'(meter_cfg.peak_fall_start);
            end else begin
                drop_peak = 1'b1;
            end
        end else begin
            if (bar > 0) begin
                bar = (bar > Q_W'(meter_cfg.bar_fall_step)) ?
                      bar - Q_W'(meter_cfg.bar_fall_step) : '0;
            end
            drop_peak = 1'b1;
        end
        if (drop_peak && peak > 0) begin
            peak  = (peak > speed) ? peak - speed : '0;
            grown = (64'(speed) * 64'(meter_cfg.peak_fall_growth)) >> 10;
            speed = (grown > 64'(Q_FULL)) ? Q_FULL : grown[Q_W-1:0];
            if (peak < bar) begin
                peak = bar;
            end
        end
        bar_q[item.band]   = bar;
        peak_q[item.band]  = peak;
        speed_q[item.band] = speed;
        res.bar_level  = bar[Q_W-1:10];
        res.peak_level = peak[Q_W-1:10];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            meter_cfg = CFG_DEFAULT;
            for (int b = 0; b < BANDS; b++) begin
                bar_q[b]   = '0;
                peak_q[b]  = '0;
                speed_q[b] = '0;
            end
            expected_levels.delete();
        end else begin
            // check the result first: it can never belong to a transaction taken now
            if (i_out_valid && i_out_ready) begin
                if (expected_levels.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result band %0d bar %0d peak %0d", $time,
                                 i_out.band_out, i_out.bar_level, i_out.peak_level);
                    end
                end else begin
                    want = expected_levels.pop_front();
                    if (i_out.band_out !== want.band_out ||
                        i_out.bar_level !== want.bar_level ||
                        i_out.peak_level !== want.peak_level) begin
                        o_mismatches++;
                        if (o_mismatches <= REPORT_LIMIT) begin
                            $display("%0t: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     $time,
                                     want.band_out, want.bar_level, want.peak_level,
                                     i_out.band_out, i_out.bar_level, i_out.peak_level);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_levels.push_back(meter_step(i_in));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HEIGHT_LIMIT:     meter_cfg.height_limit     = i_cfg_data[9:0];
                    CFG_LOG_SCALE:        meter_cfg.log_scale        = i_cfg_data;
                    CFG_BAR_FALL_STEP:    meter_cfg.bar_fall_step    = i_cfg_data;
                    CFG_PEAK_FALL_GROWTH: meter_cfg.peak_fall_growth = i_cfg_data[11:0];
                    CFG_PEAK_FALL_START:  meter_cfg.peak_fall_start  = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = expected_levels.size();
    end

endmodule

/* dv/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sbpm_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_CYCLES     = 40;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int PHASES          = 6;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in                   in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out                  out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending;
    int tx_idle_pct = 12;
    int rx_idle_pct = 65;
    bit hold_req    = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    spectrum_bar_peak_meter_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    meter_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    function automatic t_cfg make_cfg(input int mh, input int gain, input int step,
                                      input int growth, input int start);
        t_cfg c;
        c.height_limit     = 10'(mh);
        c.log_scale        = 16'(gain);
        c.bar_fall_step    = 16'(step);
        c.peak_fall_growth = 12'(growth);
        c.peak_fall_start  = 16'(start);
        return c;
    endfunction

    // most traffic on a few bands so that bars and peaks get many frames of decay
    function automatic logic [5:0] rand_band();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60) begin
            return 6'($urandom_range(3));
        end else if (sel < 80) begin
            return 6'($urandom_range(15));
        end
        return 6'($urandom_range(63));
    endfunction

    function automatic logic [15:0] rand_mag();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            return 16'd0;
        end else if (sel < 25) begin
            return 16'($urandom_range(255));
        end else if (sel < 55) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(65535, 4096));
    endfunction

    task automatic send_item(input logic [5:0] band, input logic [15:0] mag);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid          <= 1'b1;
        in_data.band      <= band;
        in_data.magnitude <= mag;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic write_config(input t_cfg c);
        put_reg(CFG_HEIGHT_LIMIT,     16'(c.height_limit));
        put_reg(CFG_LOG_SCALE,        c.log_scale);
        put_reg(CFG_BAR_FALL_STEP,    c.bar_fall_step);
        put_reg(CFG_PEAK_FALL_GROWTH, 16'(c.peak_fall_growth));
        put_reg(CFG_PEAK_FALL_START,  c.peak_fall_start);
        cfg_valid <= 1'b0;
    endtask

    // drop valid and hold until every result is back
    task automatic drain_meter();
        in_valid <= 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    task automatic run_random(input int count);
        int         sent;
        int         len;
        logic [5:0] band;
        sent = 0;
        while (sent < count) begin
            band = rand_band();
            if ($urandom_range(99) < 25) begin
                // loud hit followed by a mostly quiet tail on the same band
                send_item(band, 16'($urandom_range(65535, 8192)));
                sent++;
                len = $urandom_range(8, 2);
                repeat (len) begin
                    if ($urandom_range(3) == 0) begin
                        send_item(band, 16'($urandom_range(65535, 1024)));
                    end else begin
                        send_item(band, 16'($urandom_range(300)));
                    end
                    sent++;
                end
            end else begin
                send_item(band, rand_mag());
                sent++;
            end
        end
    endtask

    initial begin
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready)) begin
                stall = 0;
            end else begin
                stall++;
            end
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_cfg settings [PHASES];
        settings[0] = make_cfg(1023, 65535, 0, 4095, 65535);
        settings[1] = make_cfg(0, 0, 65535, 0, 0);
        // height limit well below what the previous phases left stored
        settings[2] = make_cfg(10, 300, 500, 1024, 2000);
        settings[3] = make_cfg($urandom_range(1023), $urandom_range(65535),
                               $urandom_range(65535), $urandom_range(4095),
                               $urandom_range(65535));
        settings[4] = make_cfg(200, 5000, 100, 2048, 50);
        settings[5] = make_cfg(1023, 1200, 3000, 1300, 1);

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // silence, bit patterns, low magnitudes around the log zero point
        send_item(6'd0,  16'd0);
        send_item(6'd63, 16'hFFFF);
        send_item(6'd42, 16'hAAAA);
        send_item(6'd21, 16'h5555);
        send_item(6'd1,  16'd255);
        send_item(6'd1,  16'd256);
        send_item(6'd1,  16'd257);
        send_item(6'd2,  16'd1);
        send_item(6'd2,  16'h8000);
        // new peak, then a run of silence so the peak fall speed grows
        send_item(6'd0,  16'hFFFF);
        repeat (5) send_item(6'd0, 16'd0);
        send_item(6'd0,  16'h2000);
        send_item(6'd0,  16'h0400);
        send_item(6'd0,  16'd0);
        send_item(6'd63, 16'h0100);
        send_item(6'd63, 16'hFFFF);
        drain_meter();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_config(settings[ph]);
            if (ph == 2) begin
                tx_idle_pct = 65;
                rx_idle_pct = 12;
            end else if (ph == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_req    = 1'b1;
            end
            run_random(ITEMS_PER_PHASE);
            drain_meter();
        end

        repeat (6) @(negedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
